// ===== rtl/ssig_pkg.sv =====
// Package for the spiral strip index generator.
// Holds the phase codes, the generator state and result types and grid constants.
// No dependencies.
`timescale 1ns / 1ps

package ssig_pkg;

	localparam int unsigned MAX_GRID = 128;
	localparam int unsigned IDX_W = 14;
	localparam int unsigned GRID_W = 8;
	localparam int unsigned PADDR_W = 3;
	localparam logic [GRID_W-1:0] GRID_RESET = 8'd66;
	localparam logic [PADDR_W-1:0] ADDR_GRID_SIZE = 3'd0;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_RIGHT,
		PH_DOWN,
		PH_LEFT,
		PH_UP
	} phase_t;

	typedef struct packed {
		logic [IDX_W-1:0] back_one;
		logic [IDX_W-1:0] back_two;
		logic [IDX_W-1:0] back_three;
		phase_t phase;
		logic at_corner;
		logic [GRID_W-1:0] run_length;
		logic [GRID_W-1:0] pair_counter;
		logic second_of_pair;
		logic finished;
	} gen_state_t;

	typedef struct packed {
		logic valid;
		logic [IDX_W-1:0] vertex_index;
		logic last_index;
	} gen_result_t;

endpackage

// ===== rtl/spiral_strip_index_generator_unit.sv =====
// Top level of the spiral strip index generator: request handshake, state register,
// result register and APB-style grid_size register. Depends on ssig_pkg and ssig_step.
`timescale 1ns / 1ps

// Each accepted request is turned into at most one vertex index within the cycle it is
// accepted, and the index appears on the result port in the next cycle. A new request can be
// accepted every cycle, also while a result waits, as long as that result is taken in the
// same cycle; in_ready is low only while an untaken result sits in the result register.
// A request with restart low after the final index, or after reset, gives no result.
// The grid_size register is at byte address 0 and reads back its stored value.
module spiral_strip_index_generator_unit
	import ssig_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic restart,
	output logic out_valid,
	input  logic out_ready,
	output logic [IDX_W-1:0] vertex_index,
	output logic last_index,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	gen_state_t state_q;
	gen_state_t state_next;
	gen_result_t step_res;
	logic [GRID_W-1:0] grid_size_q;
	logic out_valid_q;
	logic [IDX_W-1:0] vertex_index_q;
	logic last_index_q;
	logic in_fire;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_GRID_SIZE) ? {24'd0, grid_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_GRID_SIZE) begin
			grid_size_q <= pwdata[GRID_W-1:0];
		end
	end

	ssig_step u_step (
		.cur(state_q),
		.restart(restart),
		.grid_size(grid_size_q),
		.nxt(state_next),
		.res(step_res)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				back_one: '0,
				back_two: '0,
				back_three: '0,
				phase: PH_IDLE,
				at_corner: 1'b0,
				run_length: '0,
				pair_counter: '0,
				second_of_pair: 1'b0,
				finished: 1'b1
			};
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= step_res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && step_res.valid) begin
			vertex_index_q <= step_res.vertex_index;
			last_index_q <= step_res.last_index;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign last_index = last_index_q;

	a_last_means_finished: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_index_q |-> state_q.finished)
		else $error("final index shown while the generator is not finished");

	a_idle_only_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.finished)
		else $error("generator idle without being finished");

	a_pairs_within_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pair_counter <= state_q.run_length)
		else $error("pair counter passed the run length");

	a_restart_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && restart |=> out_valid_q && vertex_index_q == '0 && !last_index_q)
		else $error("restart request did not give index zero");

endmodule

// ===== rtl/ssig_step.sv =====
// Next-state and result logic of the spiral strip index generator for one request.
// Depends on ssig_pkg.
`timescale 1ns / 1ps

module ssig_step
	import ssig_pkg::*;
(
	input  gen_state_t cur,
	input  logic restart,
	input  logic [GRID_W-1:0] grid_size,
	output gen_state_t nxt,
	output gen_result_t res
);

	logic [GRID_W-1:0] grid_eff;
	logic [IDX_W-1:0] grid_ext;
	logic [IDX_W-1:0] step;
	logic [IDX_W-1:0] pair_sum;
	logic [GRID_W-1:0] pair_next;
	logic [GRID_W-1:0] run_dec;

	assign grid_eff = (grid_size > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_size;
	assign grid_ext = IDX_W'(grid_eff);
	assign pair_sum = cur.back_two + step;
	assign pair_next = cur.pair_counter + GRID_W'(1);
	assign run_dec = (cur.run_length != '0) ? cur.run_length - GRID_W'(1) : '0;

	always_comb begin
		unique case (cur.phase)
			PH_RIGHT: step = IDX_W'(1);
			PH_DOWN:  step = grid_ext;
			PH_LEFT:  step = '1;
			default:  step = IDX_W'(0) - grid_ext;
		endcase
	end

	always_comb begin
		nxt = cur;
		res.valid = 1'b0;
		res.vertex_index = '0;
		res.last_index = 1'b0;
		priority if (restart) begin
			nxt.back_one = '0;
			nxt.back_two = '0;
			nxt.back_three = '0;
			nxt.phase = PH_START;
			nxt.at_corner = 1'b0;
			nxt.run_length = '0;
			nxt.pair_counter = '0;
			nxt.second_of_pair = 1'b0;
			nxt.finished = 1'b0;
			res.valid = 1'b1;
		end else if (cur.finished || cur.phase == PH_IDLE) begin
			nxt = cur;
		end else if (cur.phase == PH_START) begin
			res.valid = 1'b1;
			res.vertex_index = grid_ext;
			nxt.back_three = cur.back_two;
			nxt.back_two = cur.back_one;
			nxt.back_one = grid_ext;
			nxt.run_length = (grid_eff != '0) ? grid_eff - GRID_W'(1) : '0;
			if (nxt.run_length == '0) begin
				res.last_index = 1'b1;
				nxt.finished = 1'b1;
				nxt.phase = PH_IDLE;
			end else begin
				nxt.phase = PH_RIGHT;
				nxt.pair_counter = '0;
				nxt.second_of_pair = 1'b0;
				nxt.at_corner = 1'b0;
			end
		end else if (!cur.at_corner) begin
			res.valid = 1'b1;
			res.vertex_index = pair_sum;
			nxt.back_three = cur.back_two;
			nxt.back_two = cur.back_one;
			nxt.back_one = pair_sum;
			if (cur.second_of_pair) begin
				nxt.second_of_pair = 1'b0;
				nxt.pair_counter = pair_next;
				if (pair_next >= cur.run_length) begin
					nxt.at_corner = 1'b1;
				end
			end else begin
				nxt.second_of_pair = 1'b1;
			end
		end else begin
			res.valid = 1'b1;
			res.vertex_index = cur.back_three;
			nxt.back_three = cur.back_two;
			nxt.back_two = cur.back_one;
			nxt.back_one = cur.back_three;
			nxt.pair_counter = '0;
			nxt.second_of_pair = 1'b0;
			unique case (cur.phase)
				PH_RIGHT: begin
					nxt.run_length = run_dec;
					nxt.phase = PH_DOWN;
					nxt.at_corner = (run_dec == '0);
				end
				PH_DOWN: begin
					nxt.phase = PH_LEFT;
					nxt.at_corner = (cur.run_length == '0);
				end
				PH_LEFT: begin
					nxt.run_length = run_dec;
					nxt.phase = PH_UP;
					nxt.at_corner = (run_dec == '0);
				end
				default: begin
					if (cur.run_length != '0) begin
						nxt.phase = PH_RIGHT;
						nxt.at_corner = 1'b0;
					end else begin
						res.last_index = 1'b1;
						nxt.finished = 1'b1;
						nxt.phase = PH_IDLE;
						nxt.at_corner = 1'b0;
					end
				end
			endcase
		end
	end

endmodule
